[hdl/wheel_tach_hysteresis_period_unit_macros.svh]
// Assertion macros shared by the tachometer RTL.
`ifndef WHEEL_TACH_HYSTERESIS_PERIOD_UNIT_MACROS_SVH
`define WHEEL_TACH_HYSTERESIS_PERIOD_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WTHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wthp_pkg.sv]
// Types and constants of the wheel tachometer.
`default_nettype none

package wthp_pkg;

  // Sensor edge states as reported on the output.
  localparam logic [1:0] EDGE_UNKNOWN = 2'd0;
  localparam logic [1:0] EDGE_HIGH    = 2'd1;
  localparam logic [1:0] EDGE_LOW     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESH_HIGH = 2'd0;
  localparam logic [1:0] REG_THRESH_LOW  = 2'd1;
  localparam logic [1:0] REG_MAGNETS     = 2'd2;
  localparam logic [1:0] REG_USE_DIGITAL = 2'd3;

  localparam int unsigned CFG_W = 12;

  // Timing windows in microseconds.
  localparam logic [31:0] MIN_PERIOD_US = 32'd1000;
  localparam logic [31:0] MAX_PERIOD_US = 32'd10000000;
  localparam logic [31:0] TIMEOUT_US    = 32'd2000000;
  localparam logic [10:0] US_PER_MS     = 11'd1000;

  // Speed numerator 1e6 * 2^16. The quotient is known to fit in 26 bits, so the
  // top ten bits preload the remainder and only 26 bits are shifted in.
  localparam logic [35:0] SPEED_NUM    = 36'hF_4240_0000;
  localparam logic [9:0]  SPEED_NUM_HI = SPEED_NUM[35:26];
  localparam logic [25:0] SPEED_NUM_LO = SPEED_NUM[25:0];

  // Sequencer step counts.
  localparam logic [5:0] MUL_STEPS = 6'd7;
  localparam logic [5:0] AGE_STEPS = 6'd32;
  localparam logic [5:0] RUN_LAST  = 6'd32;

  // Result beat layout.
  localparam int unsigned OUT_BITS = 108;
  localparam int unsigned OUT_W    = 112;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RUN   = 5'b00100,
    S_DONE  = 5'b01000,
    S_HOLD  = 5'b10000
  } fsm_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_en;
    logic age_en;
  } arith_ctrl_t;

endpackage

`default_nettype wire

[hdl/wthp_serial_arith.sv]
// Bit-serial multiply, speed divide and millisecond divide of the tachometer.
`default_nettype none

module wthp_serial_arith (
  input  wire                       clk_i,
  input  wire wthp_pkg::arith_ctrl_t ctrl_i,
  input  wire  [23:0]               period_i,
  input  wire  [6:0]                magnets_i,
  input  wire  [31:0]               age_diff_i,
  output logic [25:0]               speed_o,
  output logic [22:0]               age_o
);
  import wthp_pkg::*;

  logic [30:0] mcand_q, mcand_d;
  logic [6:0]  mag_q, mag_d;
  logic [30:0] prod_q, prod_d;
  logic [30:0] rem_q, rem_d;
  logic [25:0] quo_q, quo_d;
  logic [9:0]  arem_q, arem_d;
  logic [31:0] aq_q, aq_d;

  logic [31:0] div_sh;
  logic [31:0] div_sub;
  logic        div_ge;
  logic [10:0] age_sh;
  logic [10:0] age_sub;
  logic        age_ge;

  assign div_sh  = {rem_q, quo_q[25]};
  assign div_sub = div_sh - {1'b0, prod_q};
  assign div_ge  = div_sh >= {1'b0, prod_q};
  assign age_sh  = {arem_q, aq_q[31]};
  assign age_sub = age_sh - US_PER_MS;
  assign age_ge  = age_sh >= US_PER_MS;

  always_comb begin
    mcand_d = mcand_q;
    mag_d   = mag_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    arem_d  = arem_q;
    aq_d    = aq_q;
    if (ctrl_i.load) begin
      mcand_d = {7'd0, period_i};
      mag_d   = magnets_i;
      prod_d  = '0;
      rem_d   = {21'd0, SPEED_NUM_HI};
      quo_d   = SPEED_NUM_LO;
      arem_d  = '0;
      aq_d    = age_diff_i;
    end else begin
      // Shift-and-add, one multiplier bit per cycle, LSB first.
      if (ctrl_i.mul_en) begin
        if (mag_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d = {mcand_q[29:0], 1'b0};
        mag_d   = {1'b0, mag_q[6:1]};
      end
      // Restoring division; quotient bits replace the numerator bits.
      if (ctrl_i.div_en) begin
        rem_d = div_ge ? div_sub[30:0] : div_sh[30:0];
        quo_d = {quo_q[24:0], div_ge};
      end
      if (ctrl_i.age_en) begin
        arem_d = age_ge ? age_sub[9:0] : age_sh[9:0];
        aq_d   = {aq_q[30:0], age_ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    arem_q  <= arem_d;
    aq_q    <= aq_d;
  end

  assign speed_o = quo_q;
  assign age_o   = aq_q[22:0];

endmodule

`default_nettype wire

[hdl/wheel_tach_hysteresis_period_unit.sv]
// Wheel tachometer: hysteresis edge detector with pulse period and speed.
// Each input beat is one sensor poll; each one yields exactly one result beat.
// An item passes in order through the edge decision, the period checks, the
// serial arithmetic (a shift-add multiply of period by magnet count, then a
// bit-serial divide for the speed, with the divide of the pulse age by 1000
// running alongside), the commit of the speed and the load of the output
// register, which waits while an earlier result is still untaken. No new poll
// is taken until the item is through. A result waiting in the output register
// does not stop the block from taking the next poll. There is no memory and
// no start-up pass; polls are taken from the first cycle after reset.
`default_nettype none

module wheel_tach_hysteresis_period_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration writes.
  input  wire                                  cfg_we_i,
  input  wire  [1:0]                           cfg_idx_i,
  input  wire  [wthp_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Poll input: adc_sample, pin_level, now_us (from bit 0 up).
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [((SAMPLE_BITS+40)/8)*8-1:0]    s_axis_tdata,
  // Result: sensor_state, pulse_detected, pulse_total, period_us,
  // speed_rps_q16, pulse_age_ms (from bit 0 up).
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [wthp_pkg::OUT_W-1:0]           m_axis_tdata
);
  import wthp_pkg::*;

  `include "wheel_tach_hysteresis_period_unit_macros.svh"

  localparam int CMP_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam logic [11:0] THR_MASK =
    (SAMPLE_BITS >= 12) ? 12'hFFF : 12'((1 << SAMPLE_BITS) - 1);

  // Configuration registers.
  logic [11:0] th_hi_q, th_lo_q;
  logic [6:0]  magnets_q;
  logic        use_dig_q;

  // Tachometer state and per-item working registers.
  fsm_e        state_q, state_d;
  logic [1:0]  edge_q, edge_d;
  logic [31:0] count_q, count_d;
  logic [31:0] last_q, last_d;
  logic [23:0] per_q, per_d;
  logic [25:0] spd_q, spd_d;
  logic [31:0] now_q, now_d;
  logic [31:0] diff_q, diff_d;
  logic        pulse_q, pulse_d;
  logic        upd_q, upd_d;
  logic [5:0]  step_q, step_d;
  logic        m_valid_q, m_valid_d;
  logic [OUT_BITS-1:0] out_q, out_d;

  // Input fields.
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic                   pin_level;
  logic [31:0]            now_us;

  logic        in_fire;
  logic        is_high, is_low;
  logic [1:0]  edge_next;
  logic        pulse_now;
  logic        live;
  logic [31:0] age_diff;
  logic        timeout;
  logic        upd;
  logic        out_free;
  logic [6:0]  magnets;

  arith_ctrl_t ctrl;
  logic [25:0] speed;
  logic [22:0] age_ms;

  assign adc_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign pin_level  = s_axis_tdata[SAMPLE_BITS];
  assign now_us     = s_axis_tdata[SAMPLE_BITS+32:SAMPLE_BITS+1];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign magnets       = (magnets_q == 7'd0) ? 7'd1 : magnets_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_hi_q   <= 12'd2500;
      th_lo_q   <= 12'd1500;
      magnets_q <= 7'd1;
      use_dig_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESH_HIGH: th_hi_q   <= cfg_wdata_i & THR_MASK;
        REG_THRESH_LOW:  th_lo_q   <= cfg_wdata_i & THR_MASK;
        REG_MAGNETS:     magnets_q <= cfg_wdata_i[6:0];
        REG_USE_DIGITAL: use_dig_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Level judgment and edge state update.
  always_comb begin
    if (use_dig_q) begin
      is_high = pin_level;
      is_low  = !pin_level;
    end else begin
      is_high = CMP_W'(adc_sample) > CMP_W'(th_hi_q);
      is_low  = CMP_W'(adc_sample) < CMP_W'(th_lo_q);
    end
    edge_next = edge_q;
    pulse_now = 1'b0;
    unique case (edge_q)
      EDGE_HIGH: begin
        if (is_low) begin
          edge_next = EDGE_LOW;
          pulse_now = 1'b1;
        end
      end
      EDGE_LOW: begin
        if (is_high) begin
          edge_next = EDGE_HIGH;
        end
      end
      default: begin
        if (is_high) begin
          edge_next = EDGE_HIGH;
        end else if (is_low) begin
          edge_next = EDGE_LOW;
        end
      end
    endcase
  end

  // After a pulse the age counts from this poll, so it is zero.
  assign live     = pulse_q ? (now_q != 32'd0) : (last_q != 32'd0);
  assign age_diff = (live && !pulse_q) ? diff_q : 32'd0;
  assign timeout  = age_diff > TIMEOUT_US;
  assign upd      = pulse_q && (last_q != 32'd0) &&
                    (diff_q > MIN_PERIOD_US) && (diff_q < MAX_PERIOD_US);

  always_comb begin
    ctrl.load   = (state_q == S_CHECK);
    ctrl.mul_en = (state_q == S_RUN) && (step_q < MUL_STEPS);
    ctrl.div_en = (state_q == S_RUN) && (step_q >= MUL_STEPS);
    ctrl.age_en = (state_q == S_RUN) && (step_q < AGE_STEPS);
  end

  wthp_serial_arith u_arith (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .period_i   (diff_q[23:0]),
    .magnets_i  (magnets),
    .age_diff_i (age_diff),
    .speed_o    (speed),
    .age_o      (age_ms)
  );

  always_comb begin
    state_d   = state_q;
    edge_d    = edge_q;
    count_d   = count_q;
    last_d    = last_q;
    per_d     = per_q;
    spd_d     = spd_q;
    now_d     = now_q;
    diff_d    = diff_q;
    pulse_d   = pulse_q;
    upd_d     = upd_q;
    step_d    = step_q;
    out_d     = out_q;
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          edge_d  = edge_next;
          pulse_d = pulse_now;
          if (pulse_now) begin
            count_d = count_q + 32'd1;
          end
          now_d   = now_us;
          diff_d  = now_us - last_q;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pulse_q) begin
          last_d = now_q;
        end
        if (upd) begin
          per_d = diff_q[23:0];
        end
        // A timeout never coincides with an update, so the order is free.
        if (timeout) begin
          per_d = '0;
          spd_d = '0;
        end
        upd_d   = upd;
        step_d  = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        step_d = step_q + 6'd1;
        if (step_q == RUN_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (upd_q) begin
          spd_d = speed;
        end
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          out_d     = {age_ms, spd_q, per_q, count_q, pulse_q, edge_q};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      edge_q    <= EDGE_UNKNOWN;
      count_q   <= '0;
      last_q    <= '0;
      per_q     <= '0;
      spd_q     <= '0;
      pulse_q   <= 1'b0;
      upd_q     <= 1'b0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      edge_q    <= edge_d;
      count_q   <= count_d;
      last_q    <= last_d;
      per_q     <= per_d;
      spd_q     <= spd_d;
      pulse_q   <= pulse_d;
      upd_q     <= upd_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    diff_q <= diff_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_q};

  // A counted pulse always leaves the sensor judged low.
  `WTHP_ASSERT_IMPL(a_pulse_low, clk_i, rst_ni, (state_q == S_CHECK) && pulse_q,
    edge_q == EDGE_LOW, "pulse without low state")
  // Speed is only ever nonzero together with a stored period.
  `WTHP_ASSERT_IMPL(a_speed_has_period, clk_i, rst_ni, per_q == 24'd0,
    spd_q == 26'd0, "speed without period")
  // The serial run always starts from step zero and stays in range.
  `WTHP_ASSERT_NEXT(a_run_start, clk_i, rst_ni, state_q == S_CHECK,
    (state_q == S_RUN) && (step_q == 6'd0), "run did not start at step zero")
  `WTHP_ASSERT_IMPL(a_step_range, clk_i, rst_ni, state_q == S_RUN,
    step_q <= RUN_LAST, "serial step out of range")

endmodule

`default_nettype wire
